// ----- rtl/bdpc_pkg.sv -----
// Package: shared constants, command and register codes, and the configuration type for the button qualifier.
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

    // Timer and register widths
    localparam int TIMER_WIDTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > COUNT_WIDTH) ? TIMER_WIDTH : COUNT_WIDTH;
    localparam int CMD_WIDTH   = 2;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_WIDTH   = 2;

    // Command codes
    localparam logic [CMD_WIDTH-1:0] CMD_SAMPLE     = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_TAKE_LONG  = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_TAKE_SHORT = 2'd2;

    // Register indexes (byte address is 4 * index)
    localparam logic [IDX_WIDTH-1:0] REG_RELEASED_LEVEL    = 2'd0;
    localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE_COUNTS   = 2'd1;
    localparam logic [IDX_WIDTH-1:0] REG_LONG_PRESS_COUNTS = 2'd2;

    // Register reset values
    localparam logic                   RST_RELEASED_LEVEL    = 1'b0;
    localparam logic [COUNT_WIDTH-1:0] RST_DEBOUNCE_COUNTS   = 16'd50;
    localparam logic [COUNT_WIDTH-1:0] RST_LONG_PRESS_COUNTS = 16'd1000;

    // Configuration handed from the register block to the core
    typedef struct packed {
        logic                   released_level;
        logic [COUNT_WIDTH-1:0] debounce_counts;
        logic [COUNT_WIDTH-1:0] long_press_counts;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/bdpc_if.sv -----
// Interfaces: sample/command channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface bdpc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [bdpc_pkg::CMD_WIDTH-1:0]       cmd;
    logic [bdpc_pkg::TIMER_WIDTH-1:0]     now_count;
    logic                                 pin_level;

    modport source (output valid, output cmd, output now_count, output pin_level,
                    input ready);
    modport sink   (input valid, input cmd, input now_count, input pin_level,
                    output ready);
endinterface

interface bdpc_out_if;
    logic valid;
    logic ready;
    logic held;
    logic long_push;
    logic short_press;

    modport source (output valid, output held, output long_push, output short_press,
                    input ready);
    modport sink   (input valid, input held, input long_push, input short_press,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/button_debounce_press_classifier.sv -----
// Top level: push-button debounce and short/long press classifier.
`timescale 1ns / 1ps
`default_nettype none

// Each item on in_ch is either a pin sample (with the free-running timer
// count) or a take command that reports and clears one sticky press flag.
// Every item yields exactly one result on out_ch. Items pass through an input
// register and a result register; the block takes one item per cycle while
// out_ch is not stalled, and the state update (one timer subtract and two
// threshold compares) sets that rate. The result register holds a finished
// result under back-pressure while the next item waits in the input register.
// Thresholds are raw timer counts; write them over the APB-style port only
// while no items are in flight.
module button_debounce_press_classifier (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bdpc_in_if.sink                                in_ch,
    bdpc_out_if.source                             out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bdpc_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [bdpc_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic      [bdpc_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                                   pready
);
    import bdpc_pkg::*;

    cfg_t cfg;

    // Configuration registers
    bdpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Qualifier datapath
    bdpc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// ----- rtl/bdpc_cfg.sv -----
// Register block: APB-style access to the released level and the two count thresholds.
`timescale 1ns / 1ps
`default_nettype none

module bdpc_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bdpc_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [bdpc_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic      [bdpc_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                                   pready,
    output bdpc_pkg::cfg_t                         cfg
);
    import bdpc_pkg::*;

    logic                   released_level_reg;
    logic [COUNT_WIDTH-1:0] debounce_counts_reg;
    logic [COUNT_WIDTH-1:0] long_press_counts_reg;
    logic [IDX_WIDTH-1:0]   reg_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Update registers on a completed write transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            released_level_reg    <= RST_RELEASED_LEVEL;
            debounce_counts_reg   <= RST_DEBOUNCE_COUNTS;
            long_press_counts_reg <= RST_LONG_PRESS_COUNTS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RELEASED_LEVEL:    released_level_reg    <= pwdata[0];
                REG_DEBOUNCE_COUNTS:   debounce_counts_reg   <= pwdata[COUNT_WIDTH-1:0];
                REG_LONG_PRESS_COUNTS: long_press_counts_reg <= pwdata[COUNT_WIDTH-1:0];
                default:               ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_RELEASED_LEVEL:    prdata = DATA_WIDTH'(released_level_reg);
            REG_DEBOUNCE_COUNTS:   prdata = DATA_WIDTH'(debounce_counts_reg);
            REG_LONG_PRESS_COUNTS: prdata = DATA_WIDTH'(long_press_counts_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.released_level    = released_level_reg;
    assign cfg.debounce_counts   = debounce_counts_reg;
    assign cfg.long_press_counts = long_press_counts_reg;

endmodule

`default_nettype wire

// ----- rtl/bdpc_core.sv -----
// Core: input register, debounce and press classification, state flags and result register.
`timescale 1ns / 1ps
`default_nettype none

module bdpc_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bdpc_pkg::cfg_t cfg,
    bdpc_in_if.sink             in_ch,
    bdpc_out_if.source          out_ch
);
    import bdpc_pkg::*;

    // Input stage
    logic                   s1_valid_reg;
    logic [CMD_WIDTH-1:0]   s1_cmd_reg;
    logic [TIMER_WIDTH-1:0] s1_now_reg;
    logic                   s1_pin_reg;

    // Result stage
    logic out_valid_reg;
    logic out_held_reg;
    logic out_long_reg;
    logic out_short_reg;

    // Button state
    logic                   accepted_level_reg;
    logic [TIMER_WIDTH-1:0] edge_time_reg;
    logic                   long_flag_reg;
    logic                   short_flag_reg;
    logic                   held_flag_reg;

    logic                   accepted_level_next;
    logic [TIMER_WIDTH-1:0] edge_time_next;
    logic                   long_flag_next;
    logic                   short_flag_next;
    logic                   held_flag_next;

    logic                   out_free;
    logic                   s1_advance;
    logic [TIMER_WIDTH-1:0] elapsed;
    logic                   past_debounce;
    logic                   past_long;
    logic                   pressed;
    logic                   is_sample;
    logic                   edge_ok;
    logic                   long_after;
    logic                   short_after;

    // Handshake: each stage moves when the one after it is free
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_advance  = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;

    // Capture the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_cmd_reg <= in_ch.cmd;
            s1_now_reg <= in_ch.now_count;
            s1_pin_reg <= in_ch.pin_level;
        end
    end

    // Elapsed time and threshold compares
    assign elapsed       = s1_now_reg - edge_time_reg;
    assign past_debounce = CMP_WIDTH'(elapsed) > CMP_WIDTH'(cfg.debounce_counts);
    assign past_long     = CMP_WIDTH'(elapsed) > CMP_WIDTH'(cfg.long_press_counts);
    assign pressed       = s1_pin_reg != cfg.released_level;
    assign is_sample     = s1_cmd_reg == CMD_SAMPLE;
    assign edge_ok       = (s1_pin_reg != accepted_level_reg) && past_debounce;

    // Work out the state after this item
    always_comb
    begin
        accepted_level_next = accepted_level_reg;
        edge_time_next      = edge_time_reg;
        long_after          = long_flag_reg;
        short_after         = short_flag_reg;
        held_flag_next      = held_flag_reg;

        if (is_sample)
        begin
            if (edge_ok)
            begin
                accepted_level_next = s1_pin_reg;
                edge_time_next      = s1_now_reg;
                if (!pressed)
                begin
                    short_after = !past_long;
                end
            end
            else if (pressed && past_debounce && past_long)
            begin
                long_after = 1'b1;
            end
            held_flag_next = pressed;
        end

        // Take commands report the flag, then clear it
        long_flag_next  = (s1_cmd_reg == CMD_TAKE_LONG) ? 1'b0 : long_after;
        short_flag_next = (s1_cmd_reg == CMD_TAKE_SHORT) ? 1'b0 : short_after;
    end

    // Commit state as the item moves into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_level_reg <= 1'b0;
            edge_time_reg      <= '0;
            long_flag_reg      <= 1'b0;
            short_flag_reg     <= 1'b0;
            held_flag_reg      <= 1'b0;
        end
        else if (s1_advance)
        begin
            accepted_level_reg <= accepted_level_next;
            edge_time_reg      <= edge_time_next;
            long_flag_reg      <= long_flag_next;
            short_flag_reg     <= short_flag_next;
            held_flag_reg      <= held_flag_next;
        end
    end

    // Hold the result until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_held_reg  <= held_flag_next;
            out_long_reg  <= long_after;
            out_short_reg <= short_after;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.held        = out_held_reg;
    assign out_ch.long_push   = out_long_reg;
    assign out_ch.short_press = out_short_reg;

endmodule

`default_nettype wire

// ----- sim/button_debounce_press_classifier_checker.sv -----
`timescale 1ns / 1ps
// Checker for the button qualifier: tracks register writes, predicts each result and compares.
module button_debounce_press_classifier_checker
    import bdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bdpc_in_if                    in_ch,
    bdpc_out_if                   out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    input  logic                  pready,
    output int unsigned           fail_count,
    output int unsigned           pending
);

    typedef struct packed {
        logic held;
        logic long_push;
        logic short_press;
    } press_report_t;

    press_report_t expected_reports[$];

    // Register copies
    logic                   rel_level;
    logic [COUNT_WIDTH-1:0] debounce_limit;
    logic [COUNT_WIDTH-1:0] long_limit;

    // Qualifier state
    logic                   acc_level;
    logic [TIMER_WIDTH-1:0] last_edge;
    logic                   long_seen;
    logic                   short_seen;
    logic                   held_now;

    initial fail_count = 0;

    // Advance the qualifier by one item and return the report it produces
    function automatic press_report_t classify_press(input logic [CMD_WIDTH-1:0] cmd,
                                                     input logic [TIMER_WIDTH-1:0] now,
                                                     input logic pin);
        logic [TIMER_WIDTH-1:0] elapsed;
        logic                   past_debounce;
        logic                   past_long;
        logic                   pressed;
        press_report_t          report;
        if (cmd == CMD_SAMPLE)
        begin
            elapsed       = now - last_edge;
            past_debounce = elapsed > debounce_limit;
            past_long     = elapsed > long_limit;
            pressed       = pin != rel_level;
            if (pin != acc_level && past_debounce)
            begin
                // a release decides between a short press and nothing
                if (!pressed)
                    short_seen = !past_long;
                acc_level = pin;
                last_edge = now;
            end
            else if (pressed && past_debounce && past_long)
            begin
                long_seen = 1'b1;
            end
            held_now = pressed;
        end
        report.held        = held_now;
        report.long_push   = long_seen;
        report.short_press = short_seen;
        // take commands clear their flag after reporting it
        if (cmd == CMD_TAKE_LONG)
            long_seen = 1'b0;
        else if (cmd == CMD_TAKE_SHORT)
            short_seen = 1'b0;
        return report;
    endfunction

    // Follow register writes, queue predictions, check results
    always @(posedge clk or negedge rst_n)
    begin
        press_report_t want;
        press_report_t got;
        int unsigned   errs;
        if (!rst_n)
        begin
            rel_level      = RST_RELEASED_LEVEL;
            debounce_limit = RST_DEBOUNCE_COUNTS;
            long_limit     = RST_LONG_PRESS_COUNTS;
            acc_level      = 1'b0;
            last_edge      = '0;
            long_seen      = 1'b0;
            short_seen     = 1'b0;
            held_now       = 1'b0;
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_WIDTH-1:2])
                    REG_RELEASED_LEVEL:    rel_level      = pwdata[0];
                    REG_DEBOUNCE_COUNTS:   debounce_limit = pwdata[COUNT_WIDTH-1:0];
                    REG_LONG_PRESS_COUNTS: long_limit     = pwdata[COUNT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_reports.push_back(classify_press(in_ch.cmd, in_ch.now_count,
                                                          in_ch.pin_level));
            if (out_ch.valid && out_ch.ready)
            begin
                got.held        = out_ch.held;
                got.long_push   = out_ch.long_push;
                got.short_press = out_ch.short_press;
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with no prediction pending: held %b long %b short %b",
                           got.held, got.long_push, got.short_press);
                    errs++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.held !== want.held)
                    begin
                        $error("held: expected %b, actual %b", want.held, got.held);
                        errs++;
                    end
                    if (got.long_push !== want.long_push)
                    begin
                        $error("long_push: expected %b, actual %b",
                               want.long_push, got.long_push);
                        errs++;
                    end
                    if (got.short_press !== want.short_press)
                    begin
                        $error("short_press: expected %b, actual %b",
                               want.short_press, got.short_press);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= expected_reports.size();
        end
    end

endmodule

// ----- sim/button_debounce_press_classifier_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives press sequences, register writes and back-pressure, and gives the verdict.
module button_debounce_press_classifier_tb;

    import bdpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    bit          hold_off_req = 1'b0;

    // Stimulus view of the registers and of the button timer
    logic        cfg_rel;
    int unsigned cfg_deb;
    int unsigned cfg_lng;
    int unsigned clock_now;

    bdpc_in_if  in_ch ();
    bdpc_out_if out_ch ();

    button_debounce_press_classifier u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    button_debounce_press_classifier_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("button_debounce_press_classifier: mismatch");
        $finish;
    end

    // Result side: stall on changing patterns, with one long hold-off on request
    initial
    begin : result_stall
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        logic        rdy;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (cycle_count % 3 != 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // Offer one item and hold it until the transfer; gaps fall between bursts
    task automatic push_item(input logic [CMD_WIDTH-1:0] cmd, input int unsigned now,
                             input logic pin);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.now_count <= now[TIMER_WIDTH-1:0];
        in_ch.pin_level <= pin;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic idle_sender();
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back, then let the pipeline settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx,
                             input logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic rel, input int unsigned deb,
                                  input int unsigned lng);
        idle_sender();
        wait_drained();
        write_reg(REG_RELEASED_LEVEL, DATA_WIDTH'(rel));
        write_reg(REG_DEBOUNCE_COUNTS, DATA_WIDTH'(deb & 16'hFFFF));
        write_reg(REG_LONG_PRESS_COUNTS, DATA_WIDTH'(lng & 16'hFFFF));
        cfg_rel = rel;
        cfg_deb = deb & 16'hFFFF;
        cfg_lng = lng & 16'hFFFF;
    endtask

    // Contact bounce: a few samples of random level inside the debounce window
    task automatic chatter();
        int unsigned n;
        int unsigned i;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
        begin
            clock_now = clock_now + $urandom_range(0, cfg_deb / 4);
            push_item(CMD_SAMPLE, clock_now, 1'($urandom_range(0, 1)));
        end
    endtask

    // One press and release with bounce, hold samples around the long-press time
    task automatic press_cycle();
        logic        pressed_level;
        int unsigned press_t;
        int unsigned target;
        int unsigned holds;
        int unsigned i;
        pressed_level = ~cfg_rel;
        clock_now = clock_now + cfg_deb + 1 + $urandom_range(0, 60);
        push_item(CMD_SAMPLE, clock_now, pressed_level);
        press_t = clock_now;
        chatter();
        case ($urandom_range(0, 4))
            0:       target = cfg_lng;
            1:       target = cfg_lng + 1;
            2:       target = $urandom_range(0, cfg_lng);
            3:       target = cfg_lng + $urandom_range(2, 400);
            default: target = $urandom_range(0, cfg_deb + 1);
        endcase
        holds = $urandom_range(0, 3);
        for (i = 1; i <= holds; i++)
            push_item(CMD_SAMPLE, press_t + target * i / holds, pressed_level);
        if ($urandom_range(0, 2) == 0)
            push_item(CMD_TAKE_LONG, $urandom, 1'($urandom_range(0, 1)));
        clock_now = press_t + target + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
        push_item(CMD_SAMPLE, clock_now, cfg_rel);
        chatter();
        if ($urandom_range(0, 1) == 0)
            push_item(CMD_TAKE_SHORT, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                press_cycle();
            else if (pick < 9)
                push_item(CMD_WIDTH'($urandom_range(0, 3)), $urandom,
                          1'($urandom_range(0, 1)));
            else
                push_item($urandom_range(0, 1) ? CMD_TAKE_LONG : CMD_TAKE_SHORT,
                          $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    // Directed sequence on the reset settings: released low, debounce 50, long 1000
    task automatic run_directed();
        push_item(CMD_SAMPLE, 0, 1'b0);          // idle pin at time zero
        push_item(CMD_SAMPLE, 10, 1'b1);         // bounce inside the window
        push_item(CMD_SAMPLE, 51, 1'b1);         // press just past debounce
        push_item(CMD_SAMPLE, 60, 1'b0);         // release bounce
        push_item(CMD_SAMPLE, 70, 1'b1);
        push_item(CMD_TAKE_SHORT, 16'hFFFF, 1'b1);
        push_item(CMD_SAMPLE, 102, 1'b0);        // release: short press
        push_item(CMD_TAKE_SHORT, 0, 1'b0);
        push_item(CMD_TAKE_SHORT, 0, 1'b0);      // flag already cleared
        push_item(CMD_SAMPLE, 300, 1'b1);
        push_item(CMD_SAMPLE, 1300, 1'b1);       // exactly at long time: not long
        push_item(CMD_SAMPLE, 1301, 1'b1);       // one past: long
        push_item(CMD_TAKE_LONG, 16'hFFFF, 1'b0);
        push_item(CMD_TAKE_LONG, 0, 1'b1);
        push_item(CMD_SAMPLE, 1400, 1'b0);       // release after long: no short
        push_item(CMD_UNUSED, 16'hFFFF, 1'b1);
        push_item(CMD_SAMPLE, 65530, 1'b1);      // press near timer wrap
        push_item(CMD_SAMPLE, 20, 1'b0);         // wrapped bounce
        push_item(CMD_SAMPLE, 100, 1'b0);        // wrapped release
        push_item(CMD_TAKE_SHORT, 0, 1'b0);
        push_item(CMD_SAMPLE, 65535, 1'b1);
        push_item(CMD_SAMPLE, 1000, 1'b1);       // long across the wrap
        push_item(CMD_TAKE_LONG, 0, 1'b0);
        push_item(CMD_SAMPLE, 1100, 1'b0);
        push_item(CMD_UNUSED, 0, 1'b0);
        clock_now = 1100;
    endtask

    // Main stimulus
    initial
    begin
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= CMD_SAMPLE;
        in_ch.now_count <= '0;
        in_ch.pin_level <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        rst_n           <= 1'b0;
        cfg_rel   = RST_RELEASED_LEVEL;
        cfg_deb   = RST_DEBOUNCE_COUNTS;
        cfg_lng   = RST_LONG_PRESS_COUNTS;
        clock_now = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        hold_off_req = 1'b1;
        run_random(300);

        // extremes: any edge with nonzero elapsed time passes, and no press is short
        apply_settings(1'b1, 0, 0);
        run_random(250);

        // extremes: no edge ever passes
        apply_settings(1'b0, 16'hFFFF, 16'hFFFF);
        run_random(120);

        // pause until drained in the middle of a phase
        apply_settings(1'b1, $urandom_range(1, 200), $urandom_range(200, 3000));
        run_random(150);
        idle_sender();
        wait_drained();
        run_random(150);

        // long-press time below the debounce time
        apply_settings(1'b0, 100, 50);
        run_random(250);

        apply_settings(1'($urandom_range(0, 1)), $urandom_range(0, 2000),
                       $urandom_range(0, 65535));
        run_random(230);

        idle_sender();
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("button_debounce_press_classifier: match");
        else
            $display("button_debounce_press_classifier: mismatch");
        $finish;
    end

endmodule
